// ----- rtl/core/prt_pkg.sv -----
package prt_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_EDGE  = 2'd2;

    // configuration register indexes
    localparam int        CFG_IDX_W   = 3;
    localparam int        CFG_DATA_W  = 20;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd3;

    // register reset values
    localparam logic [7:0]  LOCKOUT_RST = 8'd3;
    localparam logic [6:0]  PULSES_RST  = 7'd10;
    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic [19:0] SCALE_RST   = 20'd29967;

    // microseconds per second, multiplier of the speed numerator
    localparam logic [19:0] US_PER_SEC = 20'd1000000;

    // default queue depths
    localparam int JOB_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] time_us;
    } in_t;

    typedef struct packed {
        logic [31:0] speed_q8;
        logic        timed_out;
    } out_t;

    typedef struct packed {
        logic [7:0]  lockout_ticks;
        logic [6:0]  pulses_per_measure;
        logic [15:0] timeout_ticks;
        logic [19:0] scale_q16;
    } cfg_t;

    // one finished measurement handed from front to back
    typedef struct packed {
        logic        timed_out;
        logic [6:0]  count_m1;
        logic [31:0] elapsed;
        logic [19:0] scale_q16;
    } job_t;

endpackage

// ----- rtl/core/prt_fifo.sv -----
module prt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/prt_front.sv -----
module prt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  prt_pkg::in_t  item,
    input  prt_pkg::cfg_t cfg,
    output logic          job_push,
    output prt_pkg::job_t job
);

    import prt_pkg::*;

    logic        armed_reg, armed_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] last_reg, last_next;
    logic [6:0]  edge_reg, edge_next;
    logic [31:0] first_reg, first_next;

    logic [15:0] tick_inc;
    logic [15:0] since;
    logic [6:0]  edge_inc;
    logic [31:0] first_eff;

    assign tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign since     = tick_reg - last_reg;
    assign edge_inc  = edge_reg + 7'd1;
    assign first_eff = (edge_inc == 7'd1) ? item.time_us : first_reg;

    // classify the item and update the measurement state
    always_comb
    begin
        armed_next = armed_reg;
        tick_next  = tick_reg;
        last_next  = last_reg;
        edge_next  = edge_reg;
        first_next = first_reg;
        job_push   = 1'b0;
        job        = '{timed_out: 1'b0, count_m1: edge_reg, elapsed: '0,
                       scale_q16: cfg.scale_q16};
        if (accept)
        begin
            unique case (item.cmd)
                CMD_START:
                begin
                    armed_next = 1'b1;
                    tick_next  = '0;
                    last_next  = '0;
                    edge_next  = '0;
                    first_next = '0;
                end
                CMD_TICK:
                begin
                    if (armed_reg)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.timeout_ticks)
                        begin
                            armed_next    = 1'b0;
                            job_push      = 1'b1;
                            job.timed_out = 1'b1;
                        end
                    end
                end
                CMD_EDGE:
                begin
                    if (armed_reg && (since >= {8'd0, cfg.lockout_ticks}))
                    begin
                        last_next  = tick_reg;
                        edge_next  = edge_inc;
                        first_next = first_eff;
                        if (edge_inc >= cfg.pulses_per_measure)
                        begin
                            job_push     = 1'b1;
                            job.count_m1 = edge_inc - 7'd1;
                            job.elapsed  = item.time_us - first_eff;
                            armed_next   = 1'b0;
                            tick_next    = '0;
                            last_next    = '0;
                            edge_next    = '0;
                            first_next   = '0;
                        end
                    end
                end
                default:
                begin
                    // unused command, ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            tick_reg  <= '0;
            last_reg  <= '0;
            edge_reg  <= '0;
            first_reg <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            tick_reg  <= tick_next;
            last_reg  <= last_next;
            edge_reg  <= edge_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- rtl/core/prt_back.sv -----
module prt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_empty,
    input  prt_pkg::job_t job,
    output logic          job_pop,
    input  logic          res_full,
    output logic          res_push,
    output prt_pkg::out_t res
);

    import prt_pkg::*;

    localparam int PROD_W = $bits(job.scale_q16) + $bits(job.count_m1);
    localparam int NUM_W  = PROD_W + $bits(US_PER_SEC);
    localparam int Q_W    = 32;
    localparam int HI_W   = NUM_W - 8 - Q_W;
    localparam int STEP_W = $clog2(Q_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    job_t              job_reg, job_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [Q_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    out_t              res_reg, res_next;

    logic [HI_W-1:0]   num_hi;
    logic [Q_W:0]      trial;
    logic [Q_W:0]      trial_sub;
    logic              trial_ge;

    // numerator shifted right by 8 splits into a high part and the dividend bits
    assign num_hi    = num_reg[NUM_W-1 -: HI_W];
    assign trial     = {rem_reg, quo_reg[Q_W-1]};
    assign trial_sub = trial - {1'b0, job_reg.elapsed};
    assign trial_ge  = (trial >= {1'b0, job_reg.elapsed});

    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;
    assign res_push = (state_reg == ST_DONE);
    assign res      = res_reg;

    // sequencer: two multiplies, saturation check, one quotient bit per cycle
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        job_next   = job_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_next = job;
                    if (job.timed_out)
                    begin
                        res_next   = '{speed_q8: '0, timed_out: 1'b1};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                prod_next  = PROD_W'({7'd0, job_reg.scale_q16} * {20'd0, job_reg.count_m1});
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                num_next   = NUM_W'({{(NUM_W-PROD_W){1'b0}}, prod_reg}
                                    * {{(NUM_W-$bits(US_PER_SEC)){1'b0}}, US_PER_SEC});
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                // quotient of 2^32 or more, or zero elapsed time, saturates
                if ({{(Q_W-HI_W){1'b0}}, num_hi} >= job_reg.elapsed)
                begin
                    res_next   = '{speed_q8: '1, timed_out: 1'b0};
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = {{(Q_W-HI_W){1'b0}}, num_hi};
                    quo_next   = num_reg[8 +: Q_W];
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[Q_W-1:0] : trial[Q_W-1:0];
                quo_next  = {quo_reg[Q_W-2:0], trial_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    res_next   = '{speed_q8: quo_next, timed_out: 1'b0};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
    end

    // timeout result always carries zero speed
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.timed_out |-> res.speed_q8 == '0)
        else $error("timeout result with nonzero speed");

    // partial remainder stays below the divisor during division
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < job_reg.elapsed)
        else $error("division remainder out of range");

    // a delivered result returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push && !res_full |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after transfer");

endmodule

// ----- rtl/core/pulse_rate_tachometer.sv -----
// Pulse rate tachometer. A start item arms one measurement, tick items count milliseconds
// and edge items carry microsecond timestamps; an edge counts only after the lockout number
// of ticks since the last counted edge. Once pulses_per_measure edges are counted the block
// queues speed_q8 = (edges-1)*1e6*scale_q16/(elapsed*256), saturated at all ones, or on
// reaching timeout_ticks a result with timed_out set and zero speed. The front takes one
// input item per cycle while full is low and decides it in that cycle; finished
// measurements wait in a job queue (JOB_DEPTH deep) for the back, whose multiply and
// restoring divider form a speed result; a timeout job goes straight to done. full rises
// only while the job queue is full; results wait in a RES_DEPTH deep queue until popped.
module pulse_rate_tachometer #(
    parameter int JOB_DEPTH = prt_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH = prt_pkg::RES_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  prt_pkg::in_t                    item,
    output logic                            empty,
    input  logic                            pop,
    output prt_pkg::out_t                   result,
    input  logic                            cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import prt_pkg::*;

    localparam int JOB_W = $bits(job_t);
    localparam int RES_W = $bits(out_t);

    cfg_t             cfg_reg;
    logic             accept;
    logic             job_push;
    job_t             job_in;
    logic             job_full;
    logic             job_empty;
    logic             job_pop;
    logic [JOB_W-1:0] job_bits;
    job_t             job_head;
    logic             res_push;
    logic             res_full;
    out_t             res_in;
    logic [RES_W-1:0] res_bits;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{lockout_ticks: LOCKOUT_RST, pulses_per_measure: PULSES_RST,
                         timeout_ticks: TIMEOUT_RST, scale_q16: SCALE_RST};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOCKOUT: cfg_reg.lockout_ticks      <= cfg_data[7:0];
                REG_PULSES:  cfg_reg.pulses_per_measure <= cfg_data[6:0];
                REG_TIMEOUT: cfg_reg.timeout_ticks      <= cfg_data[15:0];
                REG_SCALE:   cfg_reg.scale_q16          <= cfg_data[19:0];
                default:
                begin
                    // index beyond the register list, ignored
                end
            endcase
        end
    end

    // input transfer
    assign full   = job_full;
    assign accept = push && !full;

    prt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .job_push (job_push),
        .job      (job_in)
    );

    prt_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_bits),
        .empty   (job_empty)
    );

    assign job_head = job_bits;

    prt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    prt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign result = res_bits;

endmodule

// ----- bench/tb.sv -----
module tb;
    import prt_pkg::*;

    // the unused command code and bounds of the run
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES = 60;
    localparam int         RAND_ITEMS   = 900;
    localparam int         PHASE_ITEMS  = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    in_t                  item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    out_t                 result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted register file
    logic [7:0]  lockout_m = LOCKOUT_RST;
    logic [6:0]  pulses_m  = PULSES_RST;
    logic [15:0] timeout_m = TIMEOUT_RST;
    logic [19:0] scale_m   = SCALE_RST;

    // predicted measurement state
    bit          armed_m = 1'b0;
    logic [15:0] tick_m  = '0;
    logic [15:0] last_m  = '0;
    logic [6:0]  edges_m = '0;
    logic [31:0] first_m = '0;

    // expected results, oldest first
    out_t        rate_expect_q[$];
    out_t        front_rate;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          fail_count = 0;
    int          live_items = 0;
    int          speed_results = 0;
    int          timeout_results = 0;
    logic [31:0] now_us = '0;

    pulse_rate_tachometer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // speed in q8 from accepted edge count and elapsed microseconds
    function automatic logic [31:0] rate_q8(input logic [6:0] count, input logic [31:0] elapsed);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        if (elapsed == 32'd0)
            return 32'hFFFF_FFFF;
        num = (64'(count) - 64'd1) * 64'(US_PER_SEC) * 64'(scale_m);
        den = 64'(elapsed) * 64'd256;
        q = num / den;
        if (q > 64'h0000_0000_FFFF_FFFF)
            return 32'hFFFF_FFFF;
        return q[31:0];
    endfunction

    // advance the predicted state by one accepted item
    task automatic tach_predict(input in_t it);
        logic [15:0] since;
        logic [31:0] elapsed;
        out_t        r;
        bit          emit;
        emit = 1'b0;
        r = '0;
        if (it.cmd == CMD_START)
        begin
            armed_m = 1'b1;
            tick_m = '0;
            last_m = '0;
            edges_m = '0;
            first_m = '0;
            live_items++;
        end
        else if (armed_m && it.cmd == CMD_TICK)
        begin
            live_items++;
            if (tick_m != 16'hFFFF)
                tick_m++;
            if (tick_m >= timeout_m)
            begin
                armed_m = 1'b0;
                r.timed_out = 1'b1;
                emit = 1'b1;
            end
        end
        else if (armed_m && it.cmd == CMD_EDGE)
        begin
            live_items++;
            since = tick_m - last_m;
            if (since >= 16'(lockout_m))
            begin
                last_m = tick_m;
                edges_m++;
                if (edges_m == 7'd1)
                    first_m = it.time_us;
                if (edges_m >= pulses_m)
                begin
                    elapsed = it.time_us - first_m;
                    r.speed_q8 = rate_q8(edges_m, elapsed);
                    emit = 1'b1;
                    armed_m = 1'b0;
                    tick_m = '0;
                    last_m = '0;
                    edges_m = '0;
                    first_m = '0;
                end
            end
        end
        if (emit)
            rate_expect_q.push_back(r);
    endtask

    // offer one item until the transfer happens
    task automatic send_item(input logic [1:0] c, input logic [31:0] t);
        in_t it;
        bit  taken;
        it.cmd = c;
        it.time_us = t;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        tach_predict(it);
    endtask

    task automatic send_tick();
        now_us = now_us + 32'($urandom_range(900, 1100));
        send_item(CMD_TICK, $urandom);
    endtask

    // edge stamps mostly follow the tick clock, sometimes arbitrary
    task automatic send_edge();
        logic [31:0] t;
        if ($urandom_range(99) < 8)
            t = $urandom;
        else
            t = now_us + 32'($urandom_range(0, 999));
        send_item(CMD_EDGE, t);
    endtask

    task automatic set_idling(input int s, input int r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    // stop offering and let every expected result drain
    task automatic wait_idle();
        push <= 1'b0;
        while (rate_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_LOCKOUT: lockout_m = data[7:0];
            REG_PULSES:  pulses_m = data[6:0];
            REG_TIMEOUT: timeout_m = data[15:0];
            REG_SCALE:   scale_m = data[19:0];
            default: ;
        endcase
    endtask

    // full register set, junk in unused data bits, plus a write to a dead index
    task automatic apply_config(input logic [7:0] l, input logic [6:0] p,
                                input logic [15:0] t, input logic [19:0] s);
        wait_idle();
        reg_write(REG_LOCKOUT, {12'($urandom), l});
        reg_write(REG_PULSES, {13'($urandom), p});
        reg_write(REG_TIMEOUT, {4'($urandom), t});
        reg_write(REG_SCALE, s);
        reg_write(REG_SCALE + 3'($urandom_range(1, 4)), 20'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ticks, edges and the unused code while disarmed
    task automatic test_idle_ignored();
        set_idling(0, 0);
        send_item(CMD_TICK, $urandom);
        send_item(CMD_EDGE, $urandom);
        send_item(CMD_UNUSED, $urandom);
    endtask

    // timestamp wrap, zero elapsed and saturation
    task automatic test_wrap_and_saturation();
        logic [31:0] t;
        apply_config(8'd0, 7'd2, 16'hFFFF, 20'hFFFFF);
        send_item(CMD_START, 32'h0);
        send_item(CMD_EDGE, 32'hFFFF_FFF0);
        send_item(CMD_EDGE, 32'h0000_0010);
        t = $urandom;
        send_item(CMD_START, 32'hFFFF_FFFF);
        send_item(CMD_EDGE, t);
        send_item(CMD_EDGE, t);
        apply_config(8'd0, 7'd3, 16'hFFFF, 20'hFFFFF);
        t = $urandom;
        send_item(CMD_START, $urandom);
        send_item(CMD_EDGE, t);
        send_item(CMD_EDGE, t + 32'd1);
        send_item(CMD_EDGE, t + 32'd1);
    endtask

    // a pulse total of zero or one ends on the first accepted edge
    task automatic test_single_edge();
        apply_config(8'd0, 7'd0, 16'd100, SCALE_RST);
        send_item(CMD_START, $urandom);
        send_item(CMD_EDGE, $urandom);
        apply_config(8'd0, 7'd1, 16'd100, SCALE_RST);
        send_item(CMD_START, $urandom);
        send_item(CMD_EDGE, $urandom);
    endtask

    // a zero timeout abandons on the first tick
    task automatic test_zero_timeout();
        apply_config(8'd1, 7'd2, 16'd0, SCALE_RST);
        send_item(CMD_START, $urandom);
        send_item(CMD_TICK, $urandom);
    endtask

    // early edges are rejected, zero scale gives zero speed
    task automatic test_lockout();
        apply_config(8'd2, 7'd2, 16'd10, 20'd0);
        send_item(CMD_START, $urandom);
        send_item(CMD_EDGE, 32'd100);
        send_item(CMD_TICK, $urandom);
        send_item(CMD_TICK, $urandom);
        send_item(CMD_EDGE, 32'd2000);
        send_item(CMD_TICK, $urandom);
        send_item(CMD_EDGE, 32'd3000);
        send_item(CMD_TICK, $urandom);
        send_item(CMD_EDGE, 32'd4000);
    endtask

    // one measurement with random spacing, noise and restarts
    task automatic run_measure();
        int steps;
        int gap;
        int r;
        steps = 0;
        send_item(CMD_START, $urandom);
        while (armed_m && steps < 300)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_item(CMD_UNUSED, $urandom);
            else if (r < 6)
                send_item(CMD_START, $urandom);
            else
            begin
                if ($urandom_range(99) < 15)
                    gap = $urandom_range(0, int'(lockout_m));
                else
                    gap = int'(lockout_m) + $urandom_range(0, 2);
                repeat (gap) if (armed_m) send_tick();
                if (armed_m)
                    send_edge();
            end
            steps++;
        end
    endtask

    task automatic random_config();
        logic [7:0]  l;
        logic [6:0]  p;
        logic [15:0] t;
        logic [19:0] s;
        int          r;
        r = $urandom_range(99);
        l = 8'($urandom_range(0, 6));
        p = (r < 8) ? 7'($urandom_range(0, 1)) : 7'($urandom_range(2, 8));
        if (r >= 92)
        begin
            l = 8'd0;
            p = ($urandom_range(1) != 0) ? 7'd64 : 7'd127;
        end
        t = 16'($urandom_range(1, 60));
        r = $urandom_range(99);
        if (r < 5)
            t = 16'd0;
        else if (r < 20)
            t = 16'hFFFF;
        r = $urandom_range(99);
        if (r < 10)
            s = 20'd0;
        else if (r < 20)
            s = 20'hFFFFF;
        else
            s = 20'($urandom);
        apply_config(l, p, t, s);
    endtask

    // phases of random measurements under each idling pattern
    task automatic test_random_phases();
        int base;
        int phase_base;
        int phase;
        base = live_items;
        phase = 0;
        while (live_items - base < RAND_ITEMS)
        begin
            random_config();
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(72, 0);
                2: set_idling(0, 72);
                default: set_idling(17, 17);
            endcase
            phase_base = live_items;
            while (live_items - phase_base < PHASE_ITEMS)
            begin
                if (!armed_m && $urandom_range(99) < 20)
                    send_item(($urandom_range(1) != 0) ? CMD_TICK : CMD_EDGE, $urandom);
                run_measure();
            end
            phase++;
        end
    endtask

    // largest lockout with the widest timeout
    task automatic test_extreme_lockout();
        apply_config(8'd255, 7'd1, 16'hFFFF, 20'($urandom));
        set_idling(17, 17);
        send_item(CMD_START, $urandom);
        repeat (254) send_tick();
        send_edge();
        send_tick();
        send_edge();
    endtask

    // long receiver hold-off while items keep coming, then a full drain
    task automatic test_backpressure();
        apply_config(8'd0, 7'd2, 16'd1, 20'($urandom));
        set_idling(0, 0);
        hold_req = 400;
        repeat (12)
        begin
            send_item(CMD_START, $urandom);
            send_item(CMD_TICK, $urandom);
            send_item(CMD_START, $urandom);
            send_edge();
            send_edge();
        end
        wait_idle();
    endtask

    // receiver: random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // check each result transfer against the oldest expectation
    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (rate_expect_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result at %0t: speed_q8=%h timed_out=%b",
                             $time, result.speed_q8, result.timed_out);
            end
            else
            begin
                front_rate = rate_expect_q.pop_front();
                if (result.speed_q8 !== front_rate.speed_q8 ||
                    result.timed_out !== front_rate.timed_out)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch at %0t: exp speed=%h to=%b, got speed=%h to=%b",
                                 $time, front_rate.speed_q8, front_rate.timed_out,
                                 result.speed_q8, result.timed_out);
                end
                if (front_rate.timed_out)
                    timeout_results++;
                else
                    speed_results++;
            end
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        now_us = $urandom;
        test_idle_ignored();
        test_wrap_and_saturation();
        test_single_edge();
        test_zero_timeout();
        test_lockout();
        test_random_phases();
        test_extreme_lockout();
        test_backpressure();
        wait_idle();
        $display("covered %0d live input transfers, %0d speed and %0d timeout results",
                 live_items, speed_results, timeout_results);
        $display("with idling phases, a long receiver hold-off and extreme register values");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
